[src/rcf_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rcf_pkg
// Shared constants for the continued fraction expansion block.
// ---------------------------------------------------------------------------
package rcf_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_TERMS_DEF  = 64;

  localparam int CFG_W = 6;
  localparam logic [CFG_W-1:0] MAX_TERM_INDEX_RESET = 6'd63;

endpackage

[src/rcf_ifs.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rcf channel interfaces
// Valid/ready channels for fractions in, terms out and the config write.
// ---------------------------------------------------------------------------
interface rcf_frac_if import rcf_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] numerator;
  logic        [VALUE_BITS-2:0] denominator;

  modport source (output valid, numerator, denominator, input ready);
  modport sink   (input valid, numerator, denominator, output ready);
endinterface

interface rcf_term_if import rcf_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] term;
  logic                         last;

  modport source (output valid, term, last, input ready);
  modport sink   (input valid, term, last, output ready);
endinterface

interface rcf_cfg_if import rcf_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] max_term_index;

  modport source (output valid, max_term_index, input ready);
  modport sink   (input valid, max_term_index, output ready);
endinterface

[src/rational_to_continued_fraction_top.sv]
`timescale 1ns / 1ps
// Sequence: a term that needs a division passes S_CHECK, the S_DIV steps and S_FIX
//   before S_EMIT; a term from a denominator of 0 or 1 goes from S_CHECK to S_EMIT.
// Throughput: one fraction at a time; the next is taken only after the last term of the
//   previous one is taken, and the restoring divider yields one quotient bit per cycle.
// Reset: synchronous rst clears the sequencer to idle and max_term_index to 63.
// ---------------------------------------------------------------------------
// rational_to_continued_fraction_top
// Expands numerator/denominator into simple continued fraction terms by
// repeated floor division through one shared restoring divider.
// ---------------------------------------------------------------------------
module rational_to_continued_fraction_top import rcf_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_TERMS  = MAX_TERMS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  rcf_frac_if.sink   frac,
  rcf_term_if.source cterm,
  rcf_cfg_if.sink    cfg
);

  localparam int W     = VALUE_BITS;
  localparam int CNT_W = $clog2(W);
  localparam int TL_W  = $clog2(MAX_TERMS + 1);

  // One-hot sequencer states
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,  // wait for a fraction
    S_CHECK = 5'b00010,  // catch denominators 0 and 1, else start a division
    S_DIV   = 5'b00100,  // one quotient bit per cycle
    S_FIX   = 5'b01000,  // floor correction, next pair, term count
    S_EMIT  = 5'b10000   // hold the term until it is taken
  } state_t;

  state_t state;

  logic [CFG_W-1:0]      max_term_index;

  // Working pair; only the first numerator of a fraction can be negative
  logic signed [W-1:0]   work_num;
  logic        [W-2:0]   work_den;
  logic        [TL_W-1:0] terms_left;

  // Divider: div_quo starts as the dividend magnitude and shifts into the quotient
  logic [W-1:0]          div_quo;
  logic [W-2:0]          div_rem;
  logic [CNT_W-1:0]      div_cnt;

  // Output register
  logic signed [W-1:0]   term_q;
  logic                  last_q;

  // Divider step
  logic [W-1:0]          trial;
  logic                  trial_ge;
  logic [W-1:0]          trial_diff;

  // Term limit for a new fraction: min(max_term_index + 1, MAX_TERMS)
  logic [CFG_W:0]        limit_raw;
  logic [TL_W-1:0]       limit;

  // Floor correction results
  logic                  neg;
  logic [W-1:0]          fix_quo;
  logic [W-2:0]          fix_rem;
  logic [TL_W-1:0]       terms_left_next;

  always_comb begin
    trial      = {div_rem, div_quo[W-1]};
    trial_ge   = (trial >= {1'b0, work_den});
    trial_diff = trial - {1'b0, work_den};
  end

  always_comb begin
    limit_raw = {1'b0, max_term_index} + (CFG_W+1)'(1);
    if (limit_raw > (CFG_W+1)'(MAX_TERMS)) begin
      limit = TL_W'(MAX_TERMS);
    end else begin
      limit = TL_W'(limit_raw);
    end
  end

  // A negative dividend was divided as its magnitude: floor means quotient
  // -q-1 and remainder den-r when r is nonzero, else just -q.
  always_comb begin
    neg = work_num[W-1];
    if (neg && (div_rem != '0)) begin
      fix_quo = ~div_quo;
      fix_rem = work_den - div_rem;
    end else if (neg) begin
      fix_quo = ~div_quo + W'(1);
      fix_rem = '0;
    end else begin
      fix_quo = div_quo;
      fix_rem = div_rem;
    end
    terms_left_next = terms_left - TL_W'(1);
  end

  // Configuration: always ready; it is to be written only while idle, a rule left to the user
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_term_index <= MAX_TERM_INDEX_RESET;
    end else if (cfg.valid && cfg.ready) begin
      max_term_index <= cfg.max_term_index;
    end
  end

  assign frac.ready  = (state == S_IDLE);
  assign cterm.valid = (state == S_EMIT);
  assign cterm.term  = term_q;
  assign cterm.last  = last_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      work_num   <= '0;
      work_den   <= '0;
      terms_left <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          // Take a fraction and arm the term budget
          if (frac.valid) begin
            work_num   <= frac.numerator;
            work_den   <= frac.denominator;
            terms_left <= limit;
            state      <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (work_den == '0) begin
            // No value: one zero term, flagged last
            term_q     <= '0;
            last_q     <= 1'b1;
            terms_left <= '0;
            state      <= S_EMIT;
          end else if (work_den == (W-1)'(1)) begin
            // Denominator 1: the numerator itself closes the expansion
            term_q     <= work_num;
            last_q     <= 1'b1;
            terms_left <= '0;
            state      <= S_EMIT;
          end else begin
            div_quo <= work_num[W-1] ? (~work_num + W'(1)) : work_num;
            div_rem <= '0;
            div_cnt <= CNT_W'(W - 1);
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          // Restoring step: shift in one dividend bit, subtract if it fits
          div_rem <= trial_ge ? trial_diff[W-2:0] : trial[W-2:0];
          div_quo <= {div_quo[W-2:0], trial_ge};
          div_cnt <= div_cnt - CNT_W'(1);
          if (div_cnt == '0) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          // Advance to (den, rem); end on zero remainder or spent budget
          term_q     <= fix_quo;
          work_num   <= {1'b0, work_den};
          work_den   <= fix_rem;
          last_q     <= (fix_rem == '0) || (terms_left_next == '0);
          terms_left <= ((fix_rem == '0) || (terms_left_next == '0)) ? '0 : terms_left_next;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (cterm.ready) begin
            state <= last_q ? S_IDLE : S_CHECK;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[src/rcf_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rcf_checker
// Port-level checks of the expansion sequencing, bound to the top level.
// ---------------------------------------------------------------------------
module rcf_checker import rcf_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [VALUE_BITS-1:0] out_term,
  input logic                  out_last
);

  // Never take a fraction while a term is still on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input ready while a term is pending");

  // Hold off new fractions right after one is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready again right after accepting a fraction");

  // Return to idle after the closing term, stay busy after any other
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_last) |=> in_ready)
    else $error("not idle after last term");

  a_busy_mid_fraction: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_last) |=> !in_ready)
    else $error("idle before last term");

  // Stalled term holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_term) && $stable(out_last)))
    else $error("stalled term changed");

endmodule

bind rational_to_continued_fraction_top rcf_checker #(
  .VALUE_BITS(VALUE_BITS)
) u_rcf_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (frac.valid),
  .in_ready (frac.ready),
  .out_valid(cterm.valid),
  .out_ready(cterm.ready),
  .out_term (cterm.term),
  .out_last (cterm.last)
);
